// ===== hdl/nmrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmrp_pkg
// Widths, constants and latencies shared by the normal-map renormaliser.
// ----------------------------------------------------------------------------
package nmrp_pkg;

   localparam int BYTE_W  = 8;
   localparam int MAG_W   = 7;   // rounded magnitude 0..127
   localparam int ABS_W   = 8;   // |byte - 127| is at most 128
   localparam int SQ_W    = 15;  // square of a magnitude, at most 16384
   localparam int SUM_W   = 16;  // sum of three squares, at most 49152
   localparam int RHS_W   = 30;  // 4 * 127^2 * a^2
   localparam int T2_W    = 16;  // (2k-1)^2 for k up to 127
   localparam int PROD_W  = 32;  // (2k-1)^2 * S

   localparam logic [BYTE_W-1:0] CENTER     = 8'd127;
   localparam logic [15:0]       SCALE_SQ_X4 = 16'd64516;

   localparam int PREP_LAT = 2;
   localparam int ROOT_LAT = 2 * MAG_W + 1;
   localparam int TOTAL_LAT = PREP_LAT + ROOT_LAT;

endpackage

// ===== hdl/normal_map_renormalize_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normal_map_renormalize_pack
// Renormalises a normal-map pixel; packs metal-roughness bytes if mr_present.
// ----------------------------------------------------------------------------
// One item may be started in every cycle; busy is never raised. Each result
// appears on the rsp_ ports for one cycle with rsp_strobe high. Each item
// passes through squaring and scaling, then a bit-by-bit search of the
// seven-bit magnitude, then the output register. The receiver cannot stall.
// Write mr_present only while no items are in flight.
module normal_map_renormalize_pack (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_normal_red,
   input  logic [7:0]  req_normal_green,
   input  logic [7:0]  req_normal_blue,
   input  logic [7:0]  req_normal_alpha,
   input  logic [7:0]  req_mr_green,
   input  logic [7:0]  req_mr_blue,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_alpha,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata
);

   localparam int L = nmrp_pkg::TOTAL_LAT;

   logic                        mr_present_ff;
   logic                        accept;
   logic [L-1:0]                valid_ff;
   logic [nmrp_pkg::BYTE_W-1:0] blue_ff  [L];
   logic [nmrp_pkg::BYTE_W-1:0] alpha_ff [L];
   logic [nmrp_pkg::SUM_W-1:0]  sum_sq;
   logic [nmrp_pkg::RHS_W-1:0]  rhs_x, rhs_y;
   logic                        neg_x, neg_y;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mr_present_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         mr_present_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[L-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      blue_ff[0]  <= mr_present_ff ? req_mr_blue  : req_normal_blue;
      alpha_ff[0] <= mr_present_ff ? req_mr_green : req_normal_alpha;
      for (int i = 1; i < L; i++) begin
         blue_ff[i]  <= blue_ff[i-1];
         alpha_ff[i] <= alpha_ff[i-1];
      end
   end

   nmrp_prep u_prep (
      .clock  (clock),
      .red    (req_normal_red),
      .green  (req_normal_green),
      .blue   (req_normal_blue),
      .sum_sq (sum_sq),
      .rhs_x  (rhs_x),
      .rhs_y  (rhs_y),
      .neg_x  (neg_x),
      .neg_y  (neg_y)
   );

   nmrp_root u_root_x (
      .clock  (clock),
      .sum_sq (sum_sq),
      .rhs    (rhs_x),
      .neg    (neg_x),
      .code   (rsp_out_red)
   );

   nmrp_root u_root_y (
      .clock  (clock),
      .sum_sq (sum_sq),
      .rhs    (rhs_y),
      .neg    (neg_y),
      .code   (rsp_out_green)
   );

   assign rsp_strobe    = valid_ff[L-1];
   assign rsp_out_blue  = blue_ff[L-1];
   assign rsp_out_alpha = alpha_ff[L-1];

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, nmrp_pkg::TOTAL_LAT))
      else $error("result without a started item");

   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_out_red <= 8'd254 && rsp_out_green <= 8'd254))
      else $error("renormalised component out of range");

   a_zero_x : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_normal_red, nmrp_pkg::TOTAL_LAT) == 8'd127)
      |-> rsp_out_red == 8'd127)
      else $error("zero red component not centred");

   a_zero_y : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_normal_green, nmrp_pkg::TOTAL_LAT) == 8'd127)
      |-> rsp_out_green == 8'd127)
      else $error("zero green component not centred");
`endif

endmodule

// ===== hdl/nmrp_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmrp_prep
// Re-centres the three bytes, squares them and forms the squared length and
// the scaled right-hand side of the rounding test for red and green.
// ----------------------------------------------------------------------------
module nmrp_prep (
   input  logic                               clock,
   input  logic [nmrp_pkg::BYTE_W-1:0]        red,
   input  logic [nmrp_pkg::BYTE_W-1:0]        green,
   input  logic [nmrp_pkg::BYTE_W-1:0]        blue,
   output logic [nmrp_pkg::SUM_W-1:0]         sum_sq,
   output logic [nmrp_pkg::RHS_W-1:0]         rhs_x,
   output logic [nmrp_pkg::RHS_W-1:0]         rhs_y,
   output logic                               neg_x,
   output logic                               neg_y
);

   logic [nmrp_pkg::ABS_W-1:0] ax, ay, az;
   logic [nmrp_pkg::SQ_W-1:0]  sqx_ff, sqy_ff, sqz_ff;
   logic                       nx_ff, ny_ff;
   logic [nmrp_pkg::SUM_W-1:0] sum_ff;
   logic [nmrp_pkg::RHS_W-1:0] rx_ff, ry_ff;
   logic                       nx2_ff, ny2_ff;

   // A byte below the centre gives a negative component.
   assign ax = (red   < nmrp_pkg::CENTER) ? nmrp_pkg::CENTER - red   : red   - nmrp_pkg::CENTER;
   assign ay = (green < nmrp_pkg::CENTER) ? nmrp_pkg::CENTER - green : green - nmrp_pkg::CENTER;
   assign az = (blue  < nmrp_pkg::CENTER) ? nmrp_pkg::CENTER - blue  : blue  - nmrp_pkg::CENTER;

   always_ff @(posedge clock) begin
      sqx_ff <= nmrp_pkg::SQ_W'(ax * ax);
      sqy_ff <= nmrp_pkg::SQ_W'(ay * ay);
      sqz_ff <= nmrp_pkg::SQ_W'(az * az);
      nx_ff  <= red   < nmrp_pkg::CENTER;
      ny_ff  <= green < nmrp_pkg::CENTER;
   end

   always_ff @(posedge clock) begin
      sum_ff <= nmrp_pkg::SUM_W'(sqx_ff) + nmrp_pkg::SUM_W'(sqy_ff)
              + nmrp_pkg::SUM_W'(sqz_ff);
      rx_ff  <= nmrp_pkg::RHS_W'(nmrp_pkg::SCALE_SQ_X4 * sqx_ff);
      ry_ff  <= nmrp_pkg::RHS_W'(nmrp_pkg::SCALE_SQ_X4 * sqy_ff);
      nx2_ff <= nx_ff;
      ny2_ff <= ny_ff;
   end

   assign sum_sq = sum_ff;
   assign rhs_x  = rx_ff;
   assign rhs_y  = ry_ff;
   assign neg_x  = nx2_ff;
   assign neg_y  = ny2_ff;

endmodule

// ===== hdl/nmrp_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmrp_root
// Finds the rounded magnitude one bit per step, two stages per bit: the first
// squares the odd trial value, the second multiplies by S and compares.
// ----------------------------------------------------------------------------
module nmrp_root (
   input  logic                               clock,
   input  logic [nmrp_pkg::SUM_W-1:0]         sum_sq,
   input  logic [nmrp_pkg::RHS_W-1:0]         rhs,
   input  logic                               neg,
   output logic [nmrp_pkg::BYTE_W-1:0]        code
);

   localparam int N = nmrp_pkg::MAG_W;

   logic [nmrp_pkg::T2_W-1:0]  a_t2_ff    [N];
   logic [N-1:0]               a_trial_ff [N];
   logic [N-1:0]               a_r_ff     [N];
   logic [nmrp_pkg::SUM_W-1:0] a_s_ff     [N];
   logic [nmrp_pkg::RHS_W-1:0] a_rhs_ff   [N];
   logic                       a_neg_ff   [N];
   logic [N-1:0]               b_r_ff     [N];
   logic [nmrp_pkg::SUM_W-1:0] b_s_ff     [N];
   logic [nmrp_pkg::RHS_W-1:0] b_rhs_ff   [N];
   logic                       b_neg_ff   [N];
   logic [nmrp_pkg::BYTE_W-1:0] code_ff;

   for (genvar j = 0; j < N; j++) begin : g_step
      logic [N-1:0]               cur_r;
      logic [nmrp_pkg::SUM_W-1:0] cur_s;
      logic [nmrp_pkg::RHS_W-1:0] cur_rhs;
      logic                       cur_neg;
      logic [N-1:0]               trial;
      logic [nmrp_pkg::BYTE_W-1:0] odd;
      logic [nmrp_pkg::PROD_W-1:0] prod;
      logic                       pass;

      if (j == 0) begin : g_first
         assign cur_r   = '0;
         assign cur_s   = sum_sq;
         assign cur_rhs = rhs;
         assign cur_neg = neg;
      end else begin : g_next
         assign cur_r   = b_r_ff[j-1];
         assign cur_s   = b_s_ff[j-1];
         assign cur_rhs = b_rhs_ff[j-1];
         assign cur_neg = b_neg_ff[j-1];
      end

      assign trial = cur_r | (N'(1) << (N - 1 - j));
      assign odd   = {trial, 1'b0} - nmrp_pkg::BYTE_W'(1);

      always_ff @(posedge clock) begin
         a_t2_ff[j]    <= nmrp_pkg::T2_W'(odd * odd);
         a_trial_ff[j] <= trial;
         a_r_ff[j]     <= cur_r;
         a_s_ff[j]     <= cur_s;
         a_rhs_ff[j]   <= cur_rhs;
         a_neg_ff[j]   <= cur_neg;
      end

      assign prod = nmrp_pkg::PROD_W'(a_t2_ff[j]) * nmrp_pkg::PROD_W'(a_s_ff[j]);

      // A zero-length vector never passes, so it stays at the centre.
      assign pass = (a_s_ff[j] != '0) && (prod <= nmrp_pkg::PROD_W'(a_rhs_ff[j]));

      // The test is monotone in the trial value, so a passing bit is kept.
      always_ff @(posedge clock) begin
         b_r_ff[j]   <= pass ? a_trial_ff[j] : a_r_ff[j];
         b_s_ff[j]   <= a_s_ff[j];
         b_rhs_ff[j] <= a_rhs_ff[j];
         b_neg_ff[j] <= a_neg_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= b_neg_ff[N-1]
               ? nmrp_pkg::CENTER - nmrp_pkg::BYTE_W'(b_r_ff[N-1])
               : nmrp_pkg::CENTER + nmrp_pkg::BYTE_W'(b_r_ff[N-1]);
   end

   assign code = code_ff;

endmodule
